// File: rtl/texture_pot_nearest_rescale_assert.svh
// Assertion macros for the texture rescaler.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef TEXTURE_POT_NEAREST_RESCALE_ASSERT_SVH
`define TEXTURE_POT_NEAREST_RESCALE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge out of reset.
`define TPNR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("texture rescaler check failed");
// Check that a condition never holds at a rising clock edge out of reset.
`define TPNR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("texture rescaler forbidden condition seen");
`else
`define TPNR_ASSERT(lbl, clk, rst_n, prop)
`define TPNR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/tpnr_pkg.sv
// Shared types, constants and helper functions of the texture rescaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tpnr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SRC_TEXELS_DEF = 4096;
  localparam int unsigned MAX_OUT_DIM_DEF    = 128;
  localparam int unsigned MIN_OUT_DIM_DEF    = 8;

  // Field widths
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned TEXEL_W = 16;
  localparam int unsigned LOG_W   = 4;
  // Source index: width * row + column stays below 2^18
  localparam int unsigned SRC_W   = 19;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0] SRC_DIM_RESET = 9'd8;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [IDX_W-1:0]   texel_index;
    logic [TEXEL_W-1:0] texel_in;
  } in_item_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel_out;
    logic [DIM_W-1:0]   out_width;
    logic [DIM_W-1:0]   out_height;
    logic               was_rescaled;
    logic               read_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIM,
    ST_MUL,
    ST_INDEX,
    ST_READ,
    ST_OUT
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming word
    logic wr;      // write the incoming texel into the store
    logic dim;     // work out output size and row/column
    logic mul;     // scale row and column
    logic index;   // form the source index and check it
    logic rd;      // read the store
  } dp_cmd_t;

  // Smallest lg with 2^lg >= v; 0 for v of 0 or 1
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [DIM_W-1:0] v);
    logic [LOG_W-1:0] lg;
    lg = '0;
    for (int i = 0; i < DIM_W; i++) begin
      if ({1'b0, v} > ((DIM_W+1)'(1) << i)) begin
        lg = LOG_W'(i + 1);
      end
    end
    return lg;
  endfunction

  function automatic logic is_pow2(input logic [DIM_W-1:0] v);
    return (v & (v - DIM_W'(1))) == '0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/texture_pot_nearest_rescale.sv
// Top level of the power-of-two nearest-neighbour texture rescaler.
// Depends on tpnr_pkg, tpnr_ctrl and tpnr_datapath.
//
// Usage:
//   Input words are taken on start_i while busy_o is low. A write word
//   (opcode 0) stores texel_in at texel_index in the source store in the
//   cycle it is taken and gives no result; an index beyond the store is
//   dropped. A read word (opcode 1) returns one result word on out_o,
//   marked by done_o for exactly one cycle, once it has passed the size,
//   multiply, index and store-read steps of the shared datapath. Writes
//   can be taken back to back; a read holds busy_o high until its result
//   is given, so no new word is taken during it.
//   The source width and height are written through cfg_we_i, cfg_addr_i
//   and cfg_wdata_i while the block is idle; both reset to 8.
//   Reset clears the controller and the size registers; the store holds
//   no defined contents until written. Results cannot be stalled: the
//   receiver must take each result in the cycle done_o is high.
`timescale 1ns / 1ps
`default_nettype none

module texture_pot_nearest_rescale
  import tpnr_pkg::*;
#(
  parameter int unsigned MAX_SRC_TEXELS = MAX_SRC_TEXELS_DEF,
  parameter int unsigned MAX_OUT_DIM    = MAX_OUT_DIM_DEF,
  parameter int unsigned MIN_OUT_DIM    = MIN_OUT_DIM_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [DIM_W-1:0]     cfg_wdata_i,
  input  wire logic                 start_i,
  input  wire in_item_t             in_i,
  output logic                      busy_o,
  output logic                      done_o,
  output out_item_t                 out_o
);

  dp_cmd_t cmd;

  // Sequence the steps of each word
  tpnr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (in_i.opcode),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  // Store and arithmetic
  tpnr_datapath #(
    .MAX_SRC_TEXELS (MAX_SRC_TEXELS),
    .MAX_OUT_DIM    (MAX_OUT_DIM),
    .MIN_OUT_DIM    (MIN_OUT_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/tpnr_ctrl.sv
// Controller of the texture rescaler: issues writes and sequences one read through the datapath.
// Depends on tpnr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "texture_pot_nearest_rescale_assert.svh"

module tpnr_ctrl
  import tpnr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic opcode_i,
  output logic      busy_o,
  output logic      done_o,
  output dp_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = start_i && !busy_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (opcode_i == OP_WRITE) begin
            cmd_o.wr = 1'b1;
          end else begin
            state_d = ST_DIM;
          end
        end
      end
      ST_DIM: begin
        cmd_o.dim = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_INDEX;
      end
      ST_INDEX: begin
        cmd_o.index = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A read answers with done_o once its datapath steps are through, a write never answers
  `TPNR_ASSERT(a_read_latency, clk_i, rst_ni, (accept && opcode_i == OP_READ) |-> ##5 done_o)
  `TPNR_ASSERT(a_write_stays_idle, clk_i, rst_ni,
               (accept && opcode_i == OP_WRITE) |=> (!busy_o && !done_o))
  `TPNR_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o)
  `TPNR_ASSERT_NEVER(a_cmd_when_idle, clk_i, rst_ni,
                     !busy_o && (cmd_o.dim || cmd_o.mul || cmd_o.index || cmd_o.rd))

endmodule

`default_nettype wire

// File: rtl/tpnr_datapath.sv
// Datapath of the texture rescaler: configuration, texel store, size and
// index arithmetic. Depends on tpnr_pkg; driven by tpnr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module tpnr_datapath
  import tpnr_pkg::*;
#(
  parameter int unsigned MAX_SRC_TEXELS = MAX_SRC_TEXELS_DEF,
  parameter int unsigned MAX_OUT_DIM    = MAX_OUT_DIM_DEF,
  parameter int unsigned MIN_OUT_DIM    = MIN_OUT_DIM_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [DIM_W-1:0]       cfg_wdata_i,
  input  wire in_item_t               in_i,
  input  wire dp_cmd_t                cmd_i,
  output out_item_t                   out_o
);

  localparam int unsigned ADDR_W  = $clog2(MAX_SRC_TEXELS);
  localparam int unsigned ROW_W   = $clog2(MAX_OUT_DIM);
  localparam logic [LOG_W-1:0] LOG_MIN = LOG_W'($clog2(MIN_OUT_DIM));
  localparam logic [LOG_W-1:0] LOG_MAX = LOG_W'($clog2(MAX_OUT_DIM));

  // Configuration registers
  logic [DIM_W-1:0] w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= SRC_DIM_RESET;
      h_q <= SRC_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SRC_WIDTH:  w_q <= cfg_wdata_i;
        REG_SRC_HEIGHT: h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Texel store
  logic [TEXEL_W-1:0] mem_q [MAX_SRC_TEXELS];
  logic [ADDR_W-1:0]  addr_q;
  logic [TEXEL_W-1:0] rd_q;
  logic               wr_ok;

  assign wr_ok = {1'b0, in_i.texel_index} < (IDX_W+1)'(MAX_SRC_TEXELS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[in_i.texel_index[ADDR_W-1:0]] <= in_i.texel_in;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[addr_q];
    end
  end

  // Capture the read index
  logic [IDX_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= in_i.texel_index;
    end
  end

  // Output size, range check, row and column
  logic             rescale_d, rescale_q;
  logic [LOG_W-1:0] lw_raw, lh_raw, lw_d, lh_d, lw_q, lh_q;
  logic [LOG_W:0]   area_log;
  logic [IDX_W:0]   idx_ext;
  logic             range_err_d, range_err_q;
  logic [IDX_W-1:0] col_full;
  logic [ROW_W-1:0] row_d, row_q, col_d, col_q;

  always_comb begin
    rescale_d = !is_pow2(w_q) || !is_pow2(h_q) ||
                (w_q < DIM_W'(MIN_OUT_DIM)) || (h_q < DIM_W'(MIN_OUT_DIM));
    lw_raw = ceil_log2(w_q);
    lh_raw = ceil_log2(h_q);
    lw_d   = lw_raw;
    lh_d   = lh_raw;
    // clamp the rounded-up size into the output range
    if (rescale_d) begin
      lw_d = (lw_raw > LOG_MAX) ? LOG_MAX : ((lw_raw < LOG_MIN) ? LOG_MIN : lw_raw);
      lh_d = (lh_raw > LOG_MAX) ? LOG_MAX : ((lh_raw < LOG_MIN) ? LOG_MIN : lh_raw);
    end
    area_log    = {1'b0, lw_d} + {1'b0, lh_d};
    idx_ext     = {1'b0, idx_q};
    range_err_d = (idx_ext >> area_log) != '0;
    row_d       = ROW_W'(idx_q >> lw_d);
    col_full    = idx_q & ((IDX_W'(1) << lw_d) - IDX_W'(1));
    col_d       = col_full[ROW_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dim) begin
      rescale_q   <= rescale_d;
      lw_q        <= lw_d;
      lh_q        <= lh_d;
      range_err_q <= range_err_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

  // Scale column (centred step in unsigned integer arithmetic, (2*col+1)*w >> (lw+1)) and row
  logic [ROW_W+DIM_W:0]   col_prod;
  logic [ROW_W+DIM_W-1:0] row_prod;
  logic [ROW_W+DIM_W:0]   scol_full;
  logic [ROW_W+DIM_W-1:0] srow_full;
  logic [DIM_W-1:0]       scol_q, srow_q;

  always_comb begin
    col_prod  = {col_q, 1'b1} * {{(ROW_W+1){1'b0}}, w_q};
    row_prod  = {{DIM_W{1'b0}}, row_q} * {{ROW_W{1'b0}}, h_q};
    scol_full = col_prod >> ({1'b0, lw_q} + (LOG_W+1)'(1));
    srow_full = row_prod >> lh_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      scol_q <= scol_full[DIM_W-1:0];
      srow_q <= srow_full[DIM_W-1:0];
    end
  end

  // Form source index and check it against the store
  logic [SRC_W-1:0] src_d;
  logic             err_d, err_q;

  always_comb begin
    if (rescale_q) begin
      src_d = SRC_W'(w_q) * SRC_W'(srow_q) + SRC_W'(scol_q);
    end else begin
      src_d = SRC_W'(idx_q);
    end
    err_d = range_err_q || (src_d >= SRC_W'(MAX_SRC_TEXELS));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) begin
      addr_q <= src_d[ADDR_W-1:0];
      err_q  <= err_d;
    end
  end

  // Result word
  always_comb begin
    out_o.texel_out    = err_q ? '0 : rd_q;
    out_o.out_width    = DIM_W'(1) << lw_q;
    out_o.out_height   = DIM_W'(1) << lh_q;
    out_o.was_rescaled = rescale_q;
    out_o.read_error   = err_q;
  end

endmodule

`default_nettype wire
